[src/huffman_code_bit_packer_top_assert.svh]
// Assertion macros shared by the Huffman code bit packer checker.
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HCBP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hcbp: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HCBP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hcbp: next-cycle check failed");

`endif

[src/hcbp_pkg.sv]
// Types and constants shared by the Huffman code bit packer modules.
package hcbp_pkg;

   localparam int BYTE_BITS = 8;
   localparam int TYPE_W    = 2;
   localparam int SYM_W     = 8;
   localparam int CODE_W    = 32;
   localparam int LEN_W     = 6;

   localparam logic [TYPE_W-1:0] REQ_LOAD   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ENCODE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_FLUSH  = 2'd2;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] packed_byte;
      logic                 last_of_run;
   } rsp_payload_type;

   // One classified job for the packer: a flush, or a masked code to append.
   typedef struct packed {
      logic              is_flush;
      logic [LEN_W-1:0]  length;
      logic [CODE_W-1:0] code;
   } queue_entry_type;

endpackage

[src/hcbp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/hcbp_front.sv]
// Front end: accepts items, keeps the code table and classifies work for the packer.
module hcbp_front #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  hcbp_pkg::req_payload_type req_payload,
   output logic                      push_valid,
   input  logic                      push_ready,
   output hcbp_pkg::queue_entry_type push_entry
);
   import hcbp_pkg::*;

   localparam int IDX_W       = $clog2(SYMBOL_COUNT);
   localparam int ENTRY_W     = CODE_W + LEN_W;
   localparam int SYM_LIMIT_W = SYM_W + 1;

   logic                    accept;
   logic                    sym_ok;
   logic [IDX_W-1:0]        idx;
   logic [LEN_W-1:0]        load_len;
   logic                    wr_en;
   logic                    rd_en;
   logic [ENTRY_W-1:0]      rd_data;
   logic [SYMBOL_COUNT-1:0] valid_ff, valid_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_hit_ff;
   logic                    s1_is_flush_ff;
   logic [LEN_W-1:0]        s1_len;
   logic [CODE_W-1:0]       s1_code;
   logic [CODE_W-1:0]       code_mask;
   logic                    keep;
   logic                    is_encode;
   logic                    is_flush;

   assign accept    = req_valid && req_ready;
   assign is_encode = (req_payload.req_type == REQ_ENCODE);
   assign is_flush  = (req_payload.req_type == REQ_FLUSH);
   assign sym_ok    = {1'b0, req_payload.symbol} < SYM_LIMIT_W'(SYMBOL_COUNT);
   assign idx       = req_payload.symbol[IDX_W-1:0];
   assign load_len  = (req_payload.code_length > LEN_W'(MAX_CODE_LEN)) ?
                      LEN_W'(MAX_CODE_LEN) : req_payload.code_length;
   assign wr_en     = accept && (req_payload.req_type == REQ_LOAD) && sym_ok;
   assign rd_en     = accept && is_encode;

   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx),
      .wr_data ({req_payload.code_bits, load_len}),
      .rd_en   (rd_en),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   // An entry that was never loaded reads as length zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[idx] = 1'b1;
      end
   end

   assign s1_code   = rd_data[ENTRY_W-1:LEN_W];
   assign s1_len    = s1_hit_ff ? rd_data[LEN_W-1:0] : '0;
   assign code_mask = (s1_len >= LEN_W'(CODE_W)) ? '1 :
                      ((CODE_W'(1) << s1_len) - CODE_W'(1));
   assign keep      = s1_is_flush_ff || (s1_len != '0);

   assign req_ready   = !s1_valid_ff || !keep || push_ready;
   assign s1_valid_in = req_ready ? (req_valid && (is_encode || is_flush)) : s1_valid_ff;

   assign push_valid          = s1_valid_ff && keep;
   assign push_entry.is_flush = s1_is_flush_ff;
   assign push_entry.length   = s1_len;
   assign push_entry.code     = s1_code & code_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hit_ff      <= valid_ff[idx] && sym_ok && is_encode;
         s1_is_flush_ff <= is_flush;
      end
   end

endmodule

[src/hcbp_fifo.sv]
// Short queue of classified jobs between the front end and the packer.
module hcbp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  hcbp_pkg::queue_entry_type push_entry,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output hcbp_pkg::queue_entry_type pop_entry
);
   import hcbp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/hcbp_packer.sv]
// Back end: bit accumulator that appends codes and emits one byte per cycle while the rsp port is free.
module hcbp_packer #(
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  hcbp_pkg::queue_entry_type pop_entry,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output hcbp_pkg::rsp_payload_type rsp_payload
);
   import hcbp_pkg::*;

   localparam int ACC_W = MAX_CODE_LEN + BYTE_BITS - 1;
   localparam int TOT_W = $clog2(ACC_W + 1);

   // The low total_ff bits of the accumulator are the bits not yet emitted;
   // bits above them are stale and never reach an output byte.
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [TOT_W-1:0]     rem;
   logic [TOT_W-1:0]     byte_shift;
   logic                 out_free;
   logic                 have_byte;
   logic                 emit;
   logic                 take;
   logic                 flush_emit;
   logic [BYTE_BITS-1:0] emit_byte;
   logic [BYTE_BITS-1:0] flush_byte;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign have_byte  = (total_ff >= TOT_W'(BYTE_BITS));
   assign emit       = have_byte && out_free;
   assign byte_shift = total_ff - TOT_W'(BYTE_BITS);
   assign rem        = emit ? byte_shift : total_ff;

   // A code is appended once the bits left over after this cycle's byte fit
   // below one byte; a flush waits until every whole byte is out.
   assign pop_ready  = pop_entry.is_flush ?
                       (!have_byte && ((total_ff == '0) || out_free)) :
                       (rem < TOT_W'(BYTE_BITS));
   assign take       = pop_valid && pop_ready;
   assign flush_emit = take && pop_entry.is_flush && (total_ff != '0);

   assign emit_byte  = BYTE_BITS'(acc_ff >> byte_shift);
   assign flush_byte = acc_ff[BYTE_BITS-1:0] << (4'(BYTE_BITS) - 4'(total_ff));

   always_comb begin
      acc_in   = acc_ff;
      total_in = rem;
      if (take) begin
         if (pop_entry.is_flush) begin
            total_in = '0;
         end else begin
            acc_in   = ACC_W'((acc_ff << pop_entry.length) | ACC_W'(pop_entry.code));
            total_in = rem + TOT_W'(pop_entry.length);
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_in.packed_byte = emit_byte;
         rsp_in.last_of_run = (byte_shift < TOT_W'(BYTE_BITS));
         rsp_valid_in       = 1'b1;
      end else if (flush_emit) begin
         rsp_in.packed_byte = flush_byte;
         rsp_in.last_of_run = 1'b1;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[src/huffman_code_bit_packer_top.sv]
// Top level of the Huffman code bit packer: front end, job queue and packer.
//
// This block is the back end of a Huffman encoder. A load item writes one
// symbol's code and length into the code table, an encode item appends the
// code of a symbol to the bit stream most significant bit first, and a flush
// item pads the leftover bits with zeros into one final byte. Each completed
// byte leaves on the rsp channel, and the last byte caused by an item carries
// last_of_run. Loads, encodes of symbols whose length is zero or that lie
// beyond the table, flushes with no pending bits and request type three
// produce no output. The front end takes one item in every cycle while the
// queue has room; its code table read is registered, and it then places the
// classified job in a four-entry queue. The packer drains the queue and sends
// at most one byte per cycle, and it takes the next code only once the bits
// left after its current byte fit below one byte; a flush waits for every
// whole byte to leave. The output byte port therefore sets the sustained
// rate: one item per cycle as long as items average at most one byte each.
// When nothing is queued ahead of it, the first byte of an encode item passes
// the front-end stage, the queue and the accumulator in turn before it is
// registered on the rsp port; the byte of a flush skips the accumulator. The
// length valid bits clear at reset, so items are taken right after reset.
module huffman_code_bit_packer_top #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  hcbp_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output hcbp_pkg::rsp_payload_type rsp_payload
);
   import hcbp_pkg::*;

   // Depth of the job queue between front end and packer.
   localparam int QUEUE_DEPTH = 4;

   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_entry;
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_entry;

   // The front end owns the code table and drops loads, encodes that read as length zero and unknown request types.
   hcbp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   // The queue lets the front end keep accepting while the packer is busy
   // with a code that spans several bytes.
   hcbp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // The packer holds the pending bits and the registered output byte.
   hcbp_packer #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_packer (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[src/hcbp_checker.sv]
// Port-level checker for the Huffman code bit packer, bound to the top level.
module hcbp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input hcbp_pkg::rsp_payload_type rsp_payload
);

`include "huffman_code_bit_packer_top_assert.svh"

   // A byte that is not taken stays on the port unchanged.
   `HCBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // Nothing is in flight right after reset, so the front end must be open.
   `HCBP_ASSERT_NOW(a_ready_after_reset, $past(reset), req_ready)

   // No item can reach the output while the first accepted item is still in the front end or the queue.
   `HCBP_ASSERT_NOW(a_quiet_after_reset, $past(reset) || $past(reset, 2), !rsp_valid)

   // Nothing is queued after reset, so an offered item is taken at once.
   `HCBP_ASSERT_NOW(a_accept_after_reset, $past(reset) && req_valid, req_ready)

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_checker (.*);
